@@ rtl/gufa_pkg.sv @@
// shared constants and codes for the grid unit first-fit allocator
package gufa_pkg;

  localparam int GRID_X_DEF = 8;
  localparam int GRID_Y_DEF = 8;

  localparam int FUNC_W   = 2;
  localparam int CNT_W    = 7;
  localparam int COORD_W  = 3;
  localparam int OWNER_W  = 8;
  localparam int STATE_W  = 2;
  localparam int STATUS_W = 2;
  // row and column counters cover grids up to 16 by 16
  localparam int LOC_W    = 4;

  localparam logic [CNT_W-1:0] MAX_REQ  = 7'd64;
  localparam logic [CNT_W-1:0] SAT_FREE = 7'd127;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC   = 2'd0,
    FN_INFECT  = 2'd1,
    FN_RETREAT = 2'd2
  } func_t;

  typedef enum logic [STATE_W-1:0] {
    US_FREE     = 2'd0,
    US_INVADED  = 2'd1,
    US_INFECTED = 2'd2
  } unit_st_t;

  typedef enum logic [STATUS_W-1:0] {
    SS_OK          = 2'd0,
    SS_NO_FREE     = 2'd1,
    SS_WRONG_STATE = 2'd2
  } status_t;

endpackage

@@ rtl/grid_unit_first_fit_allocator.sv @@
// top level of the grid unit first-fit allocator
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  ---------------------------
//  request  in_func in_count in_pos_x in_pos_y      beat taken on start & !busy
//           in_owner_id
//  result   out_unit_x out_unit_y out_unit_state    one-cycle beat on out_valid
//           out_free_count out_status out_last
//
//  sequence: zero-count, refused and off-grid requests give their beat the cycle
//  after acceptance and leave busy low; infect and retreat do one status memory
//  read, then write back; an allocate scans the status memory one entry a cycle
//  in row-major order and ends once it has claimed its last unit
//  reset: synchronous, active low; all units read as free via per-entry valid
//  bits, the free count is GRID_X * GRID_Y, no clearing pass
//  the receiver cannot stall: every result beat is presented exactly once
module grid_unit_first_fit_allocator #(
  parameter int GRID_X = gufa_pkg::GRID_X_DEF,
  parameter int GRID_Y = gufa_pkg::GRID_Y_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [gufa_pkg::FUNC_W-1:0]    in_func,
  input  logic [gufa_pkg::CNT_W-1:0]     in_count,
  input  logic [gufa_pkg::COORD_W-1:0]   in_pos_x,
  input  logic [gufa_pkg::COORD_W-1:0]   in_pos_y,
  input  logic [gufa_pkg::OWNER_W-1:0]   in_owner_id,
  output logic                           out_valid,
  output logic [gufa_pkg::COORD_W-1:0]   out_unit_x,
  output logic [gufa_pkg::COORD_W-1:0]   out_unit_y,
  output logic [gufa_pkg::STATE_W-1:0]   out_unit_state,
  output logic [gufa_pkg::CNT_W-1:0]     out_free_count,
  output logic [gufa_pkg::STATUS_W-1:0]  out_status,
  output logic                           out_last
);

  import gufa_pkg::*;

  localparam int NUNITS = GRID_X * GRID_Y;
  localparam int ADDR_W = (NUNITS > 1) ? $clog2(NUNITS) : 1;
  localparam int FREE_W = $clog2(NUNITS + 1);
  localparam int EXT_W  = FREE_W + CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POINT,
    S_SCAN
  } fsm_t;

  fsm_t state_r, state_nxt;

  // captured request
  func_t                func_r, func_nxt;
  logic [COORD_W-1:0]   px_r, px_nxt;
  logic [COORD_W-1:0]   py_r, py_nxt;
  logic [ADDR_W-1:0]    idx_r, idx_nxt;
  logic [OWNER_W-1:0]   owner_r, owner_nxt;
  logic [CNT_W-1:0]     remain_r, remain_nxt;

  // scan: issue side and the read in flight
  logic [ADDR_W-1:0]    iss_addr_r, iss_addr_nxt;
  logic [LOC_W-1:0]     iss_row_r, iss_row_nxt;
  logic [LOC_W-1:0]     iss_col_r, iss_col_nxt;
  logic                 iss_end_r, iss_end_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [ADDR_W-1:0]    pend_addr_r, pend_addr_nxt;
  logic [LOC_W-1:0]     pend_row_r, pend_row_nxt;
  logic [LOC_W-1:0]     pend_col_r, pend_col_nxt;

  logic [FREE_W-1:0]    free_r, free_nxt;
  logic [NUNITS-1:0]    vld_r, vld_nxt;

  // registered result beat
  logic                 out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0]   out_x_r, out_x_nxt;
  logic [COORD_W-1:0]   out_y_r, out_y_nxt;
  logic [STATE_W-1:0]   out_st_r, out_st_nxt;
  logic [CNT_W-1:0]     out_free_r, out_free_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic                 out_last_r, out_last_nxt;

  // memory ports
  logic                 st_re;
  logic [ADDR_W-1:0]    st_raddr;
  logic [STATE_W-1:0]   st_rdata;
  logic                 st_we;
  logic [ADDR_W-1:0]    st_waddr;
  logic [STATE_W-1:0]   st_wdata;
  logic                 own_we;

  logic                 accept;
  logic                 in_grid;
  logic                 pt_req;
  logic [ADDR_W-1:0]    pt_idx;
  logic [ADDR_W-1:0]    cur_idx;
  logic [STATE_W-1:0]   cur_st;
  logic                 too_many;
  logic [EXT_W-1:0]     free_nxt_ext;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && (state_r == S_IDLE);

  assign in_grid = ({2'b00, in_pos_x} < 5'(GRID_X)) && ({2'b00, in_pos_y} < 5'(GRID_Y));
  assign pt_req  = (in_func == FN_INFECT) || (in_func == FN_RETREAT);
  assign pt_idx  = ADDR_W'(({5'd0, in_pos_x} * 8'(GRID_Y)) + {5'd0, in_pos_y});

  assign too_many = (in_count > MAX_REQ) || (EXT_W'(in_count) > EXT_W'(free_r));

  // status read: point lookup at acceptance, or the scan issue pointer
  assign st_re    = (accept && pt_req && in_grid) || ((state_r == S_SCAN) && !iss_end_r);
  assign st_raddr = (state_r == S_SCAN) ? iss_addr_r : pt_idx;

  // never-written entries read as free
  assign cur_idx = (state_r == S_POINT) ? idx_r : pend_addr_r;
  assign cur_st  = vld_r[cur_idx] ? st_rdata : US_FREE;

  gufa_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUNITS)
  ) u_status_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // owner tags are stored only
  gufa_ram #(
    .WIDTH (OWNER_W),
    .DEPTH (NUNITS)
  ) u_owner_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (pend_addr_r),
    .wdata (owner_r),
    .re    (1'b0),
    .raddr (pend_addr_r),
    .rdata ()
  );

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    idx_nxt        = idx_r;
    owner_nxt      = owner_r;
    remain_nxt     = remain_r;
    iss_addr_nxt   = iss_addr_r;
    iss_row_nxt    = iss_row_r;
    iss_col_nxt    = iss_col_r;
    iss_end_nxt    = iss_end_r;
    pend_v_nxt     = pend_v_r;
    pend_addr_nxt  = pend_addr_r;
    pend_row_nxt   = pend_row_r;
    pend_col_nxt   = pend_col_r;
    free_nxt       = free_r;
    vld_nxt        = vld_r;
    out_valid_nxt  = 1'b0;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_st_nxt     = out_st_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    st_we          = 1'b0;
    st_waddr       = pend_addr_r;
    st_wdata       = US_INVADED;
    own_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (func_t'(in_func))
            FN_ALLOC: begin
              if (in_count == '0) begin
                // empty grant
                out_valid_nxt  = 1'b1;
                out_x_nxt      = '0;
                out_y_nxt      = '0;
                out_st_nxt     = US_FREE;
                out_status_nxt = SS_OK;
                out_last_nxt   = 1'b1;
              end else if (too_many) begin
                out_valid_nxt  = 1'b1;
                out_x_nxt      = '0;
                out_y_nxt      = '0;
                out_st_nxt     = US_FREE;
                out_status_nxt = SS_NO_FREE;
                out_last_nxt   = 1'b1;
              end else begin
                state_nxt    = S_SCAN;
                owner_nxt    = in_owner_id;
                remain_nxt   = in_count;
                iss_addr_nxt = '0;
                iss_row_nxt  = '0;
                iss_col_nxt  = '0;
                iss_end_nxt  = 1'b0;
                pend_v_nxt   = 1'b0;
              end
            end
            FN_INFECT, FN_RETREAT: begin
              if (!in_grid) begin
                out_valid_nxt  = 1'b1;
                out_x_nxt      = in_pos_x;
                out_y_nxt      = in_pos_y;
                out_st_nxt     = US_FREE;
                out_status_nxt = SS_WRONG_STATE;
                out_last_nxt   = 1'b1;
              end else begin
                state_nxt = S_POINT;
                func_nxt  = func_t'(in_func);
                px_nxt    = in_pos_x;
                py_nxt    = in_pos_y;
                idx_nxt   = pt_idx;
              end
            end
            default: begin
              // unused function code: dropped without a result
            end
          endcase
        end
      end

      S_POINT: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_x_nxt     = px_r;
        out_y_nxt     = py_r;
        out_last_nxt  = 1'b1;
        st_waddr      = idx_r;
        if (func_r == FN_INFECT) begin
          if (cur_st == US_INVADED) begin
            st_we          = 1'b1;
            st_wdata       = US_INFECTED;
            vld_nxt[idx_r] = 1'b1;
            out_st_nxt     = US_INFECTED;
            out_status_nxt = SS_OK;
          end else begin
            out_st_nxt     = cur_st;
            out_status_nxt = SS_WRONG_STATE;
          end
        end else begin
          out_st_nxt = US_FREE;
          if (cur_st == US_FREE) begin
            out_status_nxt = SS_WRONG_STATE;
          end else begin
            st_we          = 1'b1;
            st_wdata       = US_FREE;
            vld_nxt[idx_r] = 1'b1;
            free_nxt       = free_r + 1'b1;
            out_status_nxt = SS_OK;
          end
        end
      end

      S_SCAN: begin
        // issue one read a cycle in row-major order
        if (!iss_end_r) begin
          pend_v_nxt    = 1'b1;
          pend_addr_nxt = iss_addr_r;
          pend_row_nxt  = iss_row_r;
          pend_col_nxt  = iss_col_r;
          iss_addr_nxt  = iss_addr_r + 1'b1;
          iss_end_nxt   = (iss_addr_r == ADDR_W'(NUNITS - 1));
          if (iss_col_r == LOC_W'(GRID_Y - 1)) begin
            iss_col_nxt = '0;
            iss_row_nxt = iss_row_r + 1'b1;
          end else begin
            iss_col_nxt = iss_col_r + 1'b1;
          end
        end else begin
          pend_v_nxt = 1'b0;
        end

        // claim the returned entry if it is free
        if (pend_v_r && (cur_st == US_FREE)) begin
          st_we                = 1'b1;
          st_wdata             = US_INVADED;
          own_we               = 1'b1;
          vld_nxt[pend_addr_r] = 1'b1;
          free_nxt             = free_r - 1'b1;
          remain_nxt           = remain_r - 1'b1;
          out_valid_nxt        = 1'b1;
          out_x_nxt            = pend_row_r[COORD_W-1:0];
          out_y_nxt            = pend_col_r[COORD_W-1:0];
          out_st_nxt           = US_INVADED;
          out_status_nxt       = SS_OK;
          out_last_nxt         = (remain_r == 7'd1);
          if (remain_r == 7'd1) begin
            // read still in flight is dropped
            state_nxt  = S_IDLE;
            pend_v_nxt = 1'b0;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // reported count saturates at the field's top
  assign free_nxt_ext = EXT_W'(free_nxt);
  assign out_free_nxt = (free_nxt_ext > EXT_W'(SAT_FREE)) ? SAT_FREE
                                                          : free_nxt_ext[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      iss_end_r   <= 1'b0;
      free_r      <= FREE_W'(NUNITS);
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      iss_end_r   <= iss_end_nxt;
      free_r      <= free_nxt;
      vld_r       <= vld_nxt;
    end
    func_r       <= func_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    idx_r        <= idx_nxt;
    owner_r      <= owner_nxt;
    remain_r     <= remain_nxt;
    iss_addr_r   <= iss_addr_nxt;
    iss_row_r    <= iss_row_nxt;
    iss_col_r    <= iss_col_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_row_r   <= pend_row_nxt;
    pend_col_r   <= pend_col_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_st_r     <= out_st_nxt;
    out_free_r   <= out_free_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_unit_x     = out_x_r;
  assign out_unit_y     = out_y_r;
  assign out_unit_state = out_st_r;
  assign out_free_count = out_free_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

endmodule

@@ rtl/gufa_ram.sv @@
// generic simple dual-port ram with registered read
module gufa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
